// File: rtl/mstwc_pkg.sv
`timescale 1ns / 1ps

package mstwc_pkg;

  // Defaults for the top-level parameters
  localparam int MaxSensorsDef  = 8;
  localparam int PayloadBitsDef = 32;

  // Fixed field widths of the ports
  localparam int WindowBits   = 40;
  localparam int CountBits    = 4;
  localparam int IndexBits    = 3;
  localparam int TsBits       = 62;
  localparam int FieldPayBits = 32;
  localparam int ReasonBits   = 2;
  localparam int CfgIndexBits = 1;

  localparam logic [WindowBits-1:0] WindowReset = 40'd100000000;
  localparam logic [CountBits-1:0]  CountReset  = 4'd1;

  // Set banks shared by the front (filling) and the back (draining)
  localparam int NumBanks = 4;
  localparam int BankBits = $clog2(NumBanks);

  typedef enum logic [ReasonBits-1:0] {
    ReasonWindow = 2'd0,
    ReasonDup    = 2'd1,
    ReasonFull   = 2'd2,
    ReasonFlush  = 2'd3
  } reason_e;

  typedef enum logic [CfgIndexBits-1:0] {
    CfgWindow = 1'b0,
    CfgCount  = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    ActArrive = 1'b0,
    ActFlush  = 1'b1
  } action_e;

  // One emitted set: which bank holds its payloads and why it was emitted
  typedef struct packed {
    logic [BankBits-1:0] bank;
    reason_e             reason;
  } set_cmd_t;

endpackage

// File: rtl/mstwc_ram.sv
`timescale 1ns / 1ps

module mstwc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/mstwc_cmd_fifo.sv
`timescale 1ns / 1ps

module mstwc_cmd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_pop;

  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: rtl/mstwc_front.sv
`timescale 1ns / 1ps

module mstwc_front #(
  parameter int MAX_SENSORS  = mstwc_pkg::MaxSensorsDef,
  parameter int PAYLOAD_BITS = mstwc_pkg::PayloadBitsDef
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // item channel
  input  logic                                   push_i,
  output logic                                   full_o,
  input  logic                                   action_i,
  input  logic [mstwc_pkg::IndexBits-1:0]        sensor_id_i,
  input  logic [mstwc_pkg::TsBits-1:0]           timestamp_i,
  input  logic [mstwc_pkg::FieldPayBits-1:0]     payload_i,
  // configuration
  input  logic [mstwc_pkg::WindowBits-1:0]       window_i,
  input  logic [$clog2(MAX_SENSORS + 1)-1:0]     used_i,
  // set commands toward the back
  input  logic                                   set_done_i,
  output logic                                   cmd_push_o,
  output mstwc_pkg::set_cmd_t                    cmd_o,
  output logic [MAX_SENSORS-1:0]                 cmd_vec_o,
  // payload store write port
  output logic                                   ram_we_o,
  output logic [mstwc_pkg::BankBits + ((MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1)-1:0]
                                                 ram_waddr_o,
  output logic [PAYLOAD_BITS-1:0]                ram_wdata_o
);

  localparam int SW = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
  localparam int OW = $clog2(mstwc_pkg::NumBanks + 1);
  localparam int TW = mstwc_pkg::TsBits + 1;
  localparam int BB = mstwc_pkg::BankBits;

  logic [MAX_SENSORS-1:0] valid_q, valid_d;
  logic [BB-1:0]          cur_q, cur_d;
  logic                   pend_q, pend_d;
  mstwc_pkg::set_cmd_t    pend_cmd_q, pend_cmd_d;
  logic [MAX_SENSORS-1:0] pend_vec_q, pend_vec_d;
  logic [mstwc_pkg::TsBits-1:0] anchor_q, anchor_d;
  logic                   anchor_set_q, anchor_set_d;
  logic [OW-1:0]          outst_q, outst_d;

  logic                   accept, in_range, outside, any_full, dup_hit;
  logic                   is_arrive, is_flush, early_win, early_dup, early, set_full;
  logic [MAX_SENSORS-1:0] onehot, mask, base_vec, new_vec;
  logic [TW-1:0]          hi_sum, lo_sum;
  logic [BB-1:0]          target;
  logic [SW-1:0]          slot;

  // Leave room for two set pushes caused by one item
  assign full_o = pend_q || (outst_q > OW'(mstwc_pkg::NumBanks - 3));
  assign accept = push_i && !full_o;
  assign slot   = SW'(sensor_id_i);

  always_comb begin
    for (int i = 0; i < MAX_SENSORS; i++) begin
      onehot[i] = (32'(sensor_id_i) == i);
      mask[i]   = (i < 32'(used_i));
    end
  end

  assign in_range = 32'(sensor_id_i) < 32'(used_i);
  assign hi_sum   = {1'b0, anchor_q} + TW'(window_i);
  assign lo_sum   = {1'b0, timestamp_i} + TW'(window_i);
  assign outside  = !anchor_set_q || ({1'b0, timestamp_i} >= hi_sum) ||
                    (lo_sum < {1'b0, anchor_q});
  assign any_full = |(valid_q & mask);
  assign dup_hit  = |(valid_q & onehot);

  assign is_arrive = accept && (mstwc_pkg::action_e'(action_i) == mstwc_pkg::ActArrive) &&
                     in_range;
  assign is_flush  = accept && (mstwc_pkg::action_e'(action_i) == mstwc_pkg::ActFlush);
  assign early_win = is_arrive && outside && any_full;
  assign early_dup = is_arrive && !early_win && dup_hit;
  assign early     = early_win || early_dup;
  assign base_vec  = early ? '0 : valid_q;
  assign new_vec   = base_vec | onehot;
  assign set_full  = is_arrive && (&(new_vec | ~mask));
  assign target    = early ? cur_q + BB'(1) : cur_q;

  always_comb begin
    cmd_push_o   = 1'b0;
    cmd_o        = '{bank: cur_q, reason: mstwc_pkg::ReasonFlush};
    cmd_vec_o    = valid_q;
    valid_d      = valid_q;
    pend_d       = 1'b0;
    pend_cmd_d   = pend_cmd_q;
    pend_vec_d   = pend_vec_q;
    anchor_d     = anchor_q;
    anchor_set_d = anchor_set_q;
    if (pend_q) begin
      // second set of the same item: the new set filled at once
      cmd_push_o = 1'b1;
      cmd_o      = pend_cmd_q;
      cmd_vec_o  = pend_vec_q;
    end else if (is_flush && any_full) begin
      cmd_push_o = 1'b1;
      valid_d    = '0;
    end else if (is_arrive) begin
      valid_d      = set_full ? '0 : new_vec;
      anchor_set_d = 1'b1;
      if (outside || early_dup || set_full) begin
        anchor_d = timestamp_i;
      end
      if (early) begin
        cmd_push_o = 1'b1;
        cmd_o      = '{bank: cur_q,
                       reason: early_win ? mstwc_pkg::ReasonWindow : mstwc_pkg::ReasonDup};
        if (set_full) begin
          pend_d     = 1'b1;
          pend_cmd_d = '{bank: target, reason: mstwc_pkg::ReasonFull};
          pend_vec_d = new_vec;
        end
      end else if (set_full) begin
        cmd_push_o = 1'b1;
        cmd_o      = '{bank: cur_q, reason: mstwc_pkg::ReasonFull};
        cmd_vec_o  = new_vec;
      end
    end
    cur_d   = cur_q + BB'(cmd_push_o);
    outst_d = outst_q + OW'(cmd_push_o) - OW'(set_done_i);
  end

  assign ram_we_o    = is_arrive;
  assign ram_waddr_o = {target, slot};
  assign ram_wdata_o = PAYLOAD_BITS'(payload_i);

  always_ff @(posedge clk_i) begin
    pend_cmd_q <= pend_cmd_d;
    pend_vec_q <= pend_vec_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      cur_q        <= '0;
      pend_q       <= 1'b0;
      anchor_q     <= '0;
      anchor_set_q <= 1'b0;
      outst_q      <= '0;
    end else begin
      valid_q      <= valid_d;
      cur_q        <= cur_d;
      pend_q       <= pend_d;
      anchor_q     <= anchor_d;
      anchor_set_q <= anchor_set_d;
      outst_q      <= outst_d;
    end
  end

  a_outst_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outst_q <= OW'(mstwc_pkg::NumBanks - 1))
    else $error("more sets in flight than banks");

  a_pend_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> cmd_push_o && !accept)
    else $error("pending full set not pushed");

endmodule

// File: rtl/mstwc_back.sv
`timescale 1ns / 1ps

module mstwc_back #(
  parameter int MAX_SENSORS  = mstwc_pkg::MaxSensorsDef,
  parameter int PAYLOAD_BITS = mstwc_pkg::PayloadBitsDef
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // set commands from the front
  input  logic                                   cmd_empty_i,
  input  mstwc_pkg::set_cmd_t                    cmd_i,
  input  logic [MAX_SENSORS-1:0]                 cmd_vec_i,
  output logic                                   cmd_pop_o,
  input  logic [$clog2(MAX_SENSORS + 1)-1:0]     used_i,
  output logic                                   set_done_o,
  // payload store read port
  output logic                                   ram_re_o,
  output logic [mstwc_pkg::BankBits + ((MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1)-1:0]
                                                 ram_raddr_o,
  input  logic [PAYLOAD_BITS-1:0]                ram_rdata_i,
  // result channel
  output logic                                   empty,
  input  logic                                   pop,
  output logic [mstwc_pkg::IndexBits-1:0]        slot_index_o,
  output logic                                   slot_valid_o,
  output logic [mstwc_pkg::FieldPayBits-1:0]     slot_payload_o,
  output logic [mstwc_pkg::ReasonBits-1:0]       yield_reason_o,
  output logic                                   last_o
);

  localparam int SW     = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
  localparam int NW     = $clog2(MAX_SENSORS + 1);
  localparam int PayOut = mstwc_pkg::FieldPayBits;

  // set being walked
  logic                   active_q;
  logic [mstwc_pkg::BankBits-1:0] bank_q;
  mstwc_pkg::reason_e     reason_q;
  logic [MAX_SENSORS-1:0] vec_q;
  logic [SW-1:0]          idx_q;
  // read in flight
  logic                   s1_v_q, s1_valid_q, s1_last_q;
  logic [SW-1:0]          s1_idx_q;
  mstwc_pkg::reason_e     s1_reason_q;
  // output register
  logic                   out_v_q, out_valid_q, out_last_q;
  logic [SW-1:0]          out_idx_q;
  mstwc_pkg::reason_e     out_reason_q;
  logic [PayOut-1:0]      out_pay_q;

  logic out_free, s1_adv, s1_free, issue, last_issue, load;

  assign out_free   = !out_v_q || pop;
  assign s1_adv     = s1_v_q && out_free;
  assign s1_free    = !s1_v_q || out_free;
  assign issue      = active_q && s1_free;
  assign last_issue = issue && (NW'(idx_q) == used_i - NW'(1));
  assign load       = !cmd_empty_i && (!active_q || last_issue);

  assign cmd_pop_o   = load;
  assign set_done_o  = last_issue;
  assign ram_re_o    = issue;
  assign ram_raddr_o = {bank_q, idx_q};

  always_ff @(posedge clk_i) begin
    if (load) begin
      bank_q   <= cmd_i.bank;
      reason_q <= cmd_i.reason;
      vec_q    <= cmd_vec_i;
    end
    if (issue) begin
      s1_idx_q    <= idx_q;
      s1_valid_q  <= vec_q[idx_q];
      s1_last_q   <= (NW'(idx_q) == used_i - NW'(1));
      s1_reason_q <= reason_q;
    end
    if (s1_adv) begin
      out_idx_q    <= s1_idx_q;
      out_valid_q  <= s1_valid_q;
      out_last_q   <= s1_last_q;
      out_reason_q <= s1_reason_q;
      out_pay_q    <= s1_valid_q ? PayOut'(ram_rdata_i) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      idx_q    <= '0;
      s1_v_q   <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (load) begin
        active_q <= 1'b1;
        idx_q    <= '0;
      end else if (last_issue) begin
        active_q <= 1'b0;
      end else if (issue) begin
        idx_q <= idx_q + SW'(1);
      end
      if (issue) begin
        s1_v_q <= 1'b1;
      end else if (s1_adv) begin
        s1_v_q <= 1'b0;
      end
      if (s1_adv) begin
        out_v_q <= 1'b1;
      end else if (pop) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign empty          = !out_v_q;
  assign slot_index_o   = mstwc_pkg::IndexBits'(out_idx_q);
  assign slot_valid_o   = out_valid_q;
  assign slot_payload_o = out_pay_q;
  assign yield_reason_o = out_reason_q;
  assign last_o         = out_last_q;

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (NW'(idx_q) < used_i))
    else $error("slot walk beyond slots in use");

  a_read_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && !out_free |=> $stable(ram_rdata_i))
    else $error("read data lost while stalled");

endmodule

// File: rtl/multi_sensor_time_window_collator.sv
`timescale 1ns / 1ps

// Multi-sensor time-window collator.
// Items enter through a queue-like port: an item is taken on a clock edge with push high
// and full low. action 0 files the payload in the slot of sensor_id_i; action 1 flushes
// the partial set. Results leave the same way: while empty is low the oldest slot result
// sits on the slot_* ports and is taken on an edge with pop high.
// An emitted set yields one result per slot in use, slot 0 first, last on the final one.
// Configuration (window length, sensor count) is written through cfg_we_i / cfg_index_i
// / cfg_data_i with no wait; the user must write it only while the block is idle, as the
// block does not enforce this. Throughput: one item per cycle while full is low; an
// emitted set drains at one slot result per cycle while results are taken. The
// front fills one of four payload banks while the back drains the others; full rises
// when fewer than two banks are free, so a burst of sets pauses input until results
// are taken. The rare item that closes two sets holds full high while the second set
// is pushed. A set's first result passes the command queue, the walk registers, the
// read stage and the output register before it is on the ports.
// Reset clears all slots, the anchor and the queues; window returns to 100 ms and the
// sensor count to one. When the receiver stalls, the result holds and the back end
// waits; the front keeps taking items until its banks run out.

module multi_sensor_time_window_collator #(
  parameter int MAX_SENSORS  = mstwc_pkg::MaxSensorsDef,
  parameter int PAYLOAD_BITS = mstwc_pkg::PayloadBitsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [mstwc_pkg::CfgIndexBits-1:0]   cfg_index_i,
  input  logic [mstwc_pkg::WindowBits-1:0]     cfg_data_i,
  // item channel
  input  logic                                 push,
  output logic                                 full,
  input  logic                                 action_i,
  input  logic [mstwc_pkg::IndexBits-1:0]      sensor_id_i,
  input  logic [mstwc_pkg::TsBits-1:0]         timestamp_i,
  input  logic [mstwc_pkg::FieldPayBits-1:0]   payload_i,
  // result channel
  output logic                                 empty,
  input  logic                                 pop,
  output logic [mstwc_pkg::IndexBits-1:0]      slot_index_o,
  output logic                                 slot_valid_o,
  output logic [mstwc_pkg::FieldPayBits-1:0]   slot_payload_o,
  output logic [mstwc_pkg::ReasonBits-1:0]     yield_reason_o,
  output logic                                 last_o
);

  localparam int SW = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
  localparam int NW = $clog2(MAX_SENSORS + 1);
  localparam int AW = mstwc_pkg::BankBits + SW;
  localparam int CmdW = MAX_SENSORS + $bits(mstwc_pkg::set_cmd_t);

  logic [mstwc_pkg::WindowBits-1:0] window_q;
  logic [mstwc_pkg::CountBits-1:0]  count_q;
  logic [NW-1:0]                    used;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= mstwc_pkg::WindowReset;
      count_q  <= mstwc_pkg::CountReset;
    end else if (cfg_we_i) begin
      unique case (mstwc_pkg::cfg_reg_e'(cfg_index_i))
        mstwc_pkg::CfgWindow: window_q <= cfg_data_i;
        mstwc_pkg::CfgCount:  count_q  <= mstwc_pkg::CountBits'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Clamp the sensor count to 1 .. MAX_SENSORS
  always_comb begin
    if (count_q == '0) begin
      used = NW'(1);
    end else if (32'(count_q) > MAX_SENSORS) begin
      used = NW'(MAX_SENSORS);
    end else begin
      used = NW'(count_q);
    end
  end

  logic                   cmd_push, cmd_pop, cmd_empty, set_done;
  mstwc_pkg::set_cmd_t    cmd_in, cmd_out;
  logic [MAX_SENSORS-1:0] vec_in, vec_out;
  logic [CmdW-1:0]        fifo_out;
  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [PAYLOAD_BITS-1:0] ram_wdata, ram_rdata;

  mstwc_front #(
    .MAX_SENSORS (MAX_SENSORS),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .action_i      (action_i),
    .sensor_id_i   (sensor_id_i),
    .timestamp_i   (timestamp_i),
    .payload_i     (payload_i),
    .window_i      (window_q),
    .used_i        (used),
    .set_done_i    (set_done),
    .cmd_push_o    (cmd_push),
    .cmd_o         (cmd_in),
    .cmd_vec_o     (vec_in),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata)
  );

  // Hold closed sets between the front and the back
  mstwc_cmd_fifo #(
    .WIDTH(CmdW),
    .DEPTH(mstwc_pkg::NumBanks)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .wdata_i({vec_in, cmd_in}),
    .pop_i  (cmd_pop),
    .empty_o(cmd_empty),
    .rdata_o(fifo_out)
  );

  assign cmd_out = mstwc_pkg::set_cmd_t'(fifo_out[$bits(mstwc_pkg::set_cmd_t)-1:0]);
  assign vec_out = fifo_out[CmdW-1:$bits(mstwc_pkg::set_cmd_t)];

  // Slot payloads, one row of slots per bank
  mstwc_ram #(
    .WIDTH(PAYLOAD_BITS),
    .DEPTH(mstwc_pkg::NumBanks << SW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  mstwc_back #(
    .MAX_SENSORS (MAX_SENSORS),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_empty_i   (cmd_empty),
    .cmd_i         (cmd_out),
    .cmd_vec_i     (vec_out),
    .cmd_pop_o     (cmd_pop),
    .used_i        (used),
    .set_done_o    (set_done),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata),
    .empty         (empty),
    .pop           (pop),
    .slot_index_o  (slot_index_o),
    .slot_valid_o  (slot_valid_o),
    .slot_payload_o(slot_payload_o),
    .yield_reason_o(yield_reason_o),
    .last_o        (last_o)
  );

endmodule
